[rtl/dktt_pkg.sv]
`default_nettype none

package dktt_pkg;

    // table size and derived widths
    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // field widths
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 3;
    localparam int PRIO_W  = 7;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int LABEL_W = 16;
    localparam int TIME_W  = HOUR_W + MIN_W + SEC_W;

    // ordering key: time or inverted priority, then slot index
    localparam int KEY_W   = TIME_W + IDX_W;
    localparam int PAD_W   = TIME_W - PRIO_W;

    // command codes
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXEC   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PRINT  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NODATA   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [LABEL_W-1:0] label;
    } t_entry;

    typedef struct packed {
        logic             before_best;
        logic             after_prev;
        logic             hit;
        logic [KEY_W-1:0] cand_key;
    } t_cmp_res;

endpackage

`default_nettype wire

[rtl/dktt_mem.sv]
`default_nettype none

module dktt_mem (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire [dktt_pkg::IDX_W-1:0]   i_waddr,
    input  wire dktt_pkg::t_entry       i_wdata,
    input  wire                         i_re,
    input  wire [dktt_pkg::IDX_W-1:0]   i_raddr,
    output dktt_pkg::t_entry            o_rdata
);

    dktt_pkg::t_entry r_mem [dktt_pkg::DEPTH];
    dktt_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/dktt_cmp.sv]
`default_nettype none

module dktt_cmp (
    input  wire dktt_pkg::t_entry           i_cand,
    input  wire [dktt_pkg::IDX_W-1:0]       i_cand_idx,
    input  wire                             i_by_time,
    input  wire [dktt_pkg::KEY_W-1:0]       i_best_key,
    input  wire [dktt_pkg::KEY_W-1:0]       i_prev_key,
    input  wire [dktt_pkg::PRIO_W-1:0]      i_key_prio,
    input  wire [dktt_pkg::TIME_W-1:0]      i_key_time,
    output dktt_pkg::t_cmp_res              o_res
);

    logic [dktt_pkg::TIME_W-1:0] cand_time;
    logic [dktt_pkg::KEY_W-1:0]  cand_key;

    // hour, minute and second are concatenated with hour in the upper bits, so the
    // time orders by hour first, then minute, then second
    assign cand_time = {i_cand.hour, i_cand.minute, i_cand.second};

    // smaller key comes first: earliest time, or highest priority, then lowest slot
    assign cand_key = i_by_time ? {cand_time, i_cand_idx}
                                : {{dktt_pkg::PAD_W{1'b0}}, ~i_cand.prio, i_cand_idx};

    assign o_res.cand_key    = cand_key;
    assign o_res.before_best = cand_key < i_best_key;
    assign o_res.after_prev  = cand_key > i_prev_key;
    assign o_res.hit         = i_by_time ? (cand_time == i_key_time)
                                         : (i_cand.prio == i_key_prio);

endmodule

`default_nettype wire

[rtl/dual_key_task_table_top.sv]
// dual_key_task_table_top: task table of 32 entries with priority and time order.
// Input channel: i_in_valid / o_in_stall with the command fields; an item is taken
// when valid is high and stall is low. Output channel: o_out_valid / i_out_stall,
// one result item per handshake, o_last marks the final result of a command.
// Add, unknown commands and any command on an empty table skip the scan; their
// result goes through the response register to the output register. Exec, next
// and change scan the table through one read port of the entry memory, one slot
// a cycle; exec then moves the later slots down, one slot a cycle. Print runs one
// full scan per result and gives one result for each of the N stored entries.
// The input stalls while a command is in progress; it is taken again as soon as
// the last result sits in the output register and, for exec, the later slots
// have moved down, even if the result is not yet taken.
// A stalled output holds its result and holds the sequencer before the next one.
// Reset empties the table and drops any pending result; the entry memory
// itself is not cleared, only slots below the entry count are read.
`default_nettype none

module dual_key_task_table_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [dktt_pkg::KIND_W-1:0]      i_kind,
    input  wire                             i_by_time,
    input  wire [dktt_pkg::PRIO_W-1:0]      i_key_prio,
    input  wire [dktt_pkg::HOUR_W-1:0]      i_key_hour,
    input  wire [dktt_pkg::MIN_W-1:0]       i_key_minute,
    input  wire [dktt_pkg::SEC_W-1:0]       i_key_second,
    input  wire [dktt_pkg::LABEL_W-1:0]     i_entry_label,
    input  wire [dktt_pkg::PRIO_W-1:0]      i_new_prio,
    input  wire [dktt_pkg::HOUR_W-1:0]      i_new_hour,
    input  wire [dktt_pkg::MIN_W-1:0]       i_new_minute,
    input  wire [dktt_pkg::SEC_W-1:0]       i_new_second,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [dktt_pkg::STAT_W-1:0]     o_status,
    output logic [dktt_pkg::PRIO_W-1:0]     o_out_prio,
    output logic [dktt_pkg::HOUR_W-1:0]     o_out_hour,
    output logic [dktt_pkg::MIN_W-1:0]      o_out_minute,
    output logic [dktt_pkg::SEC_W-1:0]      o_out_second,
    output logic [dktt_pkg::LABEL_W-1:0]    o_out_label,
    output logic                            o_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_RESP  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    localparam int IDX_W  = dktt_pkg::IDX_W;
    localparam int CNT_W  = dktt_pkg::CNT_W;
    localparam int KEY_W  = dktt_pkg::KEY_W;
    localparam int TIME_W = dktt_pkg::TIME_W;

    // control state
    logic [1:0]       r_state,     n_state;
    logic [1:0]       r_after,     n_after;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [CNT_W-1:0] r_iss,       n_iss;
    logic [CNT_W-1:0] r_pass,      n_pass;
    logic             r_dv,        n_dv;
    logic             r_best_ok,   n_best_ok;
    logic             r_hit,       n_hit;
    logic             r_have_prev, n_have_prev;
    logic             r_out_valid, n_out_valid;

    // command and scan data
    logic [dktt_pkg::KIND_W-1:0]  r_kind,      n_kind;
    logic                         r_by_time,   n_by_time;
    logic [dktt_pkg::PRIO_W-1:0]  r_key_prio,  n_key_prio;
    logic [TIME_W-1:0]            r_key_time,  n_key_time;
    logic [dktt_pkg::PRIO_W-1:0]  r_new_prio,  n_new_prio;
    logic [TIME_W-1:0]            r_new_time,  n_new_time;
    logic [IDX_W-1:0]             r_didx,      n_didx;
    logic [KEY_W-1:0]             r_best_key,  n_best_key;
    logic [IDX_W-1:0]             r_best_idx,  n_best_idx;
    dktt_pkg::t_entry             r_best_ent,  n_best_ent;
    logic [IDX_W-1:0]             r_hit_idx,   n_hit_idx;
    dktt_pkg::t_entry             r_hit_ent,   n_hit_ent;
    logic [KEY_W-1:0]             r_prev_key,  n_prev_key;
    logic [dktt_pkg::STAT_W-1:0]  r_res_status, n_res_status;
    logic                         r_res_last,  n_res_last;
    dktt_pkg::t_entry             r_res_ent,   n_res_ent;
    logic [dktt_pkg::STAT_W-1:0]  r_out_status, n_out_status;
    logic                         r_out_last,  n_out_last;
    dktt_pkg::t_entry             r_out_ent,   n_out_ent;

    // memory and compare unit hookup
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    dktt_pkg::t_entry     mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    dktt_pkg::t_entry     mem_rdata;
    dktt_pkg::t_entry     add_ent;
    dktt_pkg::t_entry     chg_ent;
    dktt_pkg::t_cmp_res   cmp;

    logic in_acc;
    logic out_free;
    logic scan_end;
    logic elig;
    logic print_last;

    dktt_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dktt_cmp u_cmp (
        .i_cand     (mem_rdata),
        .i_cand_idx (r_didx),
        .i_by_time  (r_by_time),
        .i_best_key (r_best_key),
        .i_prev_key (r_prev_key),
        .i_key_prio (r_key_prio),
        .i_key_time (r_key_time),
        .o_res      (cmp)
    );

    // handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // scan bookkeeping
    assign scan_end   = (r_iss == r_count) && !r_dv;
    assign elig       = !r_have_prev || cmp.after_prev;
    assign print_last = (r_pass == (r_count - CNT_W'(1)));

    // new entry from the input ports
    assign add_ent.prio   = i_key_prio;
    assign add_ent.hour   = i_key_hour;
    assign add_ent.minute = i_key_minute;
    assign add_ent.second = i_key_second;
    assign add_ent.label  = i_entry_label;

    // rewritten entry for change
    always_comb begin
        chg_ent = r_hit_ent;
        if (r_by_time) begin
            {chg_ent.hour, chg_ent.minute, chg_ent.second} = r_new_time;
        end else begin
            chg_ent.prio = r_new_prio;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_after      = r_after;
        n_count      = r_count;
        n_iss        = r_iss;
        n_pass       = r_pass;
        n_dv         = r_dv;
        n_best_ok    = r_best_ok;
        n_hit        = r_hit;
        n_have_prev  = r_have_prev;
        n_out_valid  = r_out_valid;
        n_kind       = r_kind;
        n_by_time    = r_by_time;
        n_key_prio   = r_key_prio;
        n_key_time   = r_key_time;
        n_new_prio   = r_new_prio;
        n_new_time   = r_new_time;
        n_didx       = r_didx;
        n_best_key   = r_best_key;
        n_best_idx   = r_best_idx;
        n_best_ent   = r_best_ent;
        n_hit_idx    = r_hit_idx;
        n_hit_ent    = r_hit_ent;
        n_prev_key   = r_prev_key;
        n_res_status = r_res_status;
        n_res_last   = r_res_last;
        n_res_ent    = r_res_ent;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_ent    = r_out_ent;
        mem_we       = 1'b0;
        mem_waddr    = r_didx - IDX_W'(1);
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = r_iss[IDX_W-1:0];

        // output register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind     = i_kind;
                    n_by_time  = i_by_time;
                    n_key_prio = i_key_prio;
                    n_key_time = {i_key_hour, i_key_minute, i_key_second};
                    n_new_prio = i_new_prio;
                    n_new_time = {i_new_hour, i_new_minute, i_new_second};
                    n_res_ent  = '0;
                    n_res_last = 1'b1;
                    n_after    = S_IDLE;
                    priority if (i_kind > dktt_pkg::KIND_PRINT) begin
                        n_res_status = dktt_pkg::ST_NODATA;
                        n_state      = S_RESP;
                    end else if (i_kind == dktt_pkg::KIND_ADD) begin
                        if (r_count == CNT_W'(dktt_pkg::DEPTH)) begin
                            n_res_status = dktt_pkg::ST_FULL;
                        end else begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_count[IDX_W-1:0];
                            mem_wdata    = add_ent;
                            n_count      = r_count + CNT_W'(1);
                            n_res_status = dktt_pkg::ST_NODATA;
                        end
                        n_state = S_RESP;
                    end else if (r_count == '0) begin
                        n_res_status = dktt_pkg::ST_EMPTY;
                        n_state      = S_RESP;
                    end else begin
                        n_iss       = '0;
                        n_dv        = 1'b0;
                        n_best_ok   = 1'b0;
                        n_hit       = 1'b0;
                        n_have_prev = 1'b0;
                        n_pass      = '0;
                        n_state     = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // issue one read a cycle
                mem_re = (r_iss < r_count);
                n_dv   = mem_re;
                n_didx = r_iss[IDX_W-1:0];
                if (mem_re) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                // compare the slot read last cycle
                if (r_dv) begin
                    if (elig && (!r_best_ok || cmp.before_best)) begin
                        n_best_ok  = 1'b1;
                        n_best_key = cmp.cand_key;
                        n_best_idx = r_didx;
                        n_best_ent = mem_rdata;
                    end
                    if (cmp.hit && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_didx;
                        n_hit_ent = mem_rdata;
                    end
                end
                // finish the pass
                if (scan_end) begin
                    n_state    = S_RESP;
                    n_after    = S_IDLE;
                    n_res_last = 1'b1;
                    n_res_ent  = '0;
                    priority if (r_kind == dktt_pkg::KIND_CHANGE) begin
                        if (r_hit) begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_hit_idx;
                            mem_wdata    = chg_ent;
                            n_res_status = dktt_pkg::ST_NODATA;
                        end else begin
                            n_res_status = dktt_pkg::ST_NOTFOUND;
                        end
                    end else if (r_kind == dktt_pkg::KIND_PRINT) begin
                        n_res_status = dktt_pkg::ST_OK;
                        n_res_ent    = r_best_ent;
                        n_res_last   = print_last;
                        n_after      = print_last ? S_IDLE : S_SCAN;
                        n_prev_key   = r_best_key;
                        n_have_prev  = 1'b1;
                        n_pass       = r_pass + CNT_W'(1);
                        n_iss        = '0;
                        n_best_ok    = 1'b0;
                    end else begin
                        n_res_status = dktt_pkg::ST_OK;
                        n_res_ent    = r_best_ent;
                        if (r_kind == dktt_pkg::KIND_EXEC) begin
                            n_after = S_SHIFT;
                            n_iss   = CNT_W'(r_best_idx) + CNT_W'(1);
                        end
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_last   = r_res_last;
                    n_out_ent    = r_res_ent;
                    n_state      = r_after;
                end
            end

            S_SHIFT: begin
                // move each later slot down by one
                mem_re = (r_iss < r_count);
                n_dv   = mem_re;
                n_didx = r_iss[IDX_W-1:0];
                if (mem_re) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (r_dv) begin
                    mem_we = 1'b1;
                end
                if (scan_end) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_count     <= '0;
            r_iss       <= '0;
            r_pass      <= '0;
            r_dv        <= 1'b0;
            r_best_ok   <= 1'b0;
            r_hit       <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_count     <= n_count;
            r_iss       <= n_iss;
            r_pass      <= n_pass;
            r_dv        <= n_dv;
            r_best_ok   <= n_best_ok;
            r_hit       <= n_hit;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_by_time    <= n_by_time;
        r_key_prio   <= n_key_prio;
        r_key_time   <= n_key_time;
        r_new_prio   <= n_new_prio;
        r_new_time   <= n_new_time;
        r_didx       <= n_didx;
        r_best_key   <= n_best_key;
        r_best_idx   <= n_best_idx;
        r_best_ent   <= n_best_ent;
        r_hit_idx    <= n_hit_idx;
        r_hit_ent    <= n_hit_ent;
        r_prev_key   <= n_prev_key;
        r_res_status <= n_res_status;
        r_res_last   <= n_res_last;
        r_res_ent    <= n_res_ent;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_ent    <= n_out_ent;
    end

    // output ports
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_out_prio   = r_out_ent.prio;
    assign o_out_hour   = r_out_ent.hour;
    assign o_out_minute = r_out_ent.minute;
    assign o_out_second = r_out_ent.second;
    assign o_out_label  = r_out_ent.label;
    assign o_last       = r_out_last;

`ifndef SYNTHESIS
    // entry count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(dktt_pkg::DEPTH))
        else $error("entry count beyond table size");

    // an accepted add on a non-full table grows the count by one
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == dktt_pkg::KIND_ADD && r_count != CNT_W'(dktt_pkg::DEPTH))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("add did not grow the table");

    // read issue pointer stays within the stored entries
    a_iss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> (r_iss <= r_count))
        else $error("scan pointer past entry count");

    // slot removal only runs on a non-empty table
    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count != '0))
        else $error("shift on empty table");

    // every print pass reports a stored entry
    a_print_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_kind == dktt_pkg::KIND_PRINT) |-> (r_pass < r_count))
        else $error("print pass beyond entry count");
`endif

endmodule

`default_nettype wire
